// ----- src/mp2e_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2e_pkg
// Shared types, codes and fixed-point helpers of the MP2 energy engine.
// ----------------------------------------------------------------------------
package mp2e_pkg;

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_ENERGY,
    KIND_INTEGRAL,
    KIND_START
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_RND,
    ST_ACC,
    ST_EREAD,
    ST_DIFF,
    ST_DIFF2,
    ST_DIFFQ,
    ST_QMUL,
    ST_QSET,
    ST_DIV,
    ST_QFIN,
    ST_EACC,
    ST_OUT
  } state_t;

  localparam logic CFG_OCC   = 1'b0;
  localparam logic CFG_BASIS = 1'b1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  localparam int NUM_W     = 79;
  localparam int DEN_W     = 34;
  localparam int DIV_STEPS = 79;

  localparam logic [2:0] RD_LAST   = 3'd4;
  localparam logic [2:0] K_D_LAST  = 3'd3;
  localparam logic [2:0] K_X_LAST  = 3'd7;

  localparam logic signed [63:0] Q64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] Q64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [64:0] C32_MAX = 65'sd2147483647;
  localparam logic signed [64:0] C32_MIN = -65'sd2147483648;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } sat32_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] v;
  } sat64_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] dvs;
  } div_ctl_t;

  function automatic sat32_t clamp32(input logic signed [64:0] xv);
    sat32_t r;
    r.sat = 1'b0;
    r.v   = xv[31:0];
    if (xv > C32_MAX) begin
      r.sat = 1'b1;
      r.v   = 32'sh7fff_ffff;
    end else if (xv < C32_MIN) begin
      r.sat = 1'b1;
      r.v   = 32'sh8000_0000;
    end
    return r;
  endfunction

  // q8.24 product back to q8.24, round half up
  function automatic sat32_t rnd24(input logic signed [63:0] pv);
    logic signed [64:0] t;
    t = $signed({pv[63], pv}) + 65'sd8388608;
    t = t >>> 24;
    return clamp32(t);
  endfunction

  // q8.24 times q8.24 down to q24.40
  function automatic logic signed [63:0] rnd8(input logic signed [63:0] pv);
    logic signed [64:0] t;
    t = $signed({pv[63], pv}) + 65'sd128;
    t = t >>> 8;
    return t[63:0];
  endfunction

  function automatic sat64_t addsat(input logic signed [63:0] av,
                                    input logic signed [63:0] bv);
    logic signed [64:0] s;
    sat64_t r;
    s = $signed({av[63], av}) + $signed({bv[63], bv});
    r.sat = s[64] ^ s[63];
    r.v   = r.sat ? (s[64] ? Q64_MIN : Q64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sat64_t subsat(input logic signed [63:0] av,
                                    input logic signed [63:0] bv);
    logic signed [64:0] s;
    sat64_t r;
    s = $signed({av[63], av}) - $signed({bv[63], bv});
    r.sat = s[64] ^ s[63];
    r.v   = r.sat ? (s[64] ? Q64_MIN : Q64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sat32_t to_q24(input logic signed [63:0] xv);
    logic signed [64:0] t;
    t = $signed({xv[63], xv}) >>> 16;
    t = t + $signed({64'd0, xv[15]});
    return clamp32(t);
  endfunction

endpackage

// ----- src/mp2e_ram.sv -----
// ----------------------------------------------------------------------------
// mp2e_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mp2e_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mp2e_mul.sv -----
// ----------------------------------------------------------------------------
// mp2e_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module mp2e_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

// ----- src/mp2e_div.sv -----
// ----------------------------------------------------------------------------
// mp2e_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mp2e_div import mp2e_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    sh       = {rem, quo[NUM_W-1]};
    trial    = sh - {1'b0, dvs};
    qbit     = ~trial[DEN_W];
    rem_next = qbit ? trial[DEN_W-1:0] : sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        cnt <= CW'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  // quo shifts the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= ctl.num;
      dvs <= ctl.dvs;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], qbit};
    end
  end

endmodule

// ----- src/mp2_energy_reduction.sv -----
// ----------------------------------------------------------------------------
// mp2_energy_reduction
// Closed-shell MP2 correlation energy engine with a shared multiplier.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser picks coefficient, orbital energy, integral or
// start; tdata carries the row-major slot and a q8.24 value. Load beats are
// taken back to back while idle and give no result. A start beat runs the
// MP2 sum and returns one beat on m_axis with the q24.40 energy and two flags.
// Config writes (occupied count, basis size) go over cfg_*; the user must
// make them only when idle, the block itself does not enforce it. The sum
// runs on the one 32x32 multiplier: an inner step is five reads and eight
// multiplies; each energy term ends with a bit-serial divide, skipped on a
// zero denominator. s_axis is not ready while the sum runs. The result sits
// in an output register; if m_axis stalls, the next loads and a new start
// are still taken, and the new result waits for the register to drain.
// Reset (rst, synchronous) returns to idle with occupied count 1 and basis
// size 8; store contents are not cleared.
// ----------------------------------------------------------------------------
module mp2_energy_reduction import mp2e_pkg::*; #(
  parameter int MAX_BASIS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot[11:0], value[43:12]
  input  logic [1:0]             s_axis_tuser,  // kind[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // energy[63:0], zero_denominator[64], saturated[65]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [5:0]             cfg_data
);

  localparam int IW     = $clog2(MAX_BASIS);
  localparam int NW     = $clog2(MAX_BASIS + 1);
  localparam int CDEPTH = MAX_BASIS * MAX_BASIS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int IFULL  = CDEPTH * CDEPTH;
  localparam int IDEPTH = (IFULL > 4096) ? 4096 : IFULL;
  localparam int IAW    = $clog2(IDEPTH);
  localparam int AW4    = 4 * NW;
  localparam int AW2    = 2 * NW;

  state_t state, state_next;

  logic [5:0] occupied_count, basis_size;
  logic [NW-1:0] n_r, occ_r, n_last, occ_last;
  logic [5:0] n_c6, occ_c6;
  logic empty;

  logic [IW-1:0] ii, jj, aa, bb, mm, tt, ll, ss;
  logic [2:0] rd, k;
  logic signed [31:0] zi, za, zj, zb, g1, g2, p, dq, diffq;
  logic signed [63:0] d, x, term, diff, qv, energy;
  logic signed [33:0] den;
  logic zero_den, sat;
  logic inner_last, outer_last, den_nz, out_free;

  logic in_acc, cfg_acc, start;
  kind_t kind;
  logic [11:0] slot;
  logic [31:0] value;

  logic [31:0] coef_rd, eng_rd, int_rd;
  logic [CAW-1:0] coef_raddr;
  logic [IAW-1:0] int_raddr;
  logic [IW-1:0]  eng_raddr;
  logic [AW2-1:0] caddr_full;
  logic [AW4-1:0] g1_full, g2_full;
  logic [IW-1:0]  cp, cq;

  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [63:0]        un;

  div_ctl_t         div_ctl;
  logic             div_done;
  logic [NUM_W-1:0] quo;

  sat32_t r24, dq_s, df_s;
  sat64_t dd_s, ds_s, acc_s;
  logic q_neg, q_big;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cfg_acc = cfg_valid & cfg_ready;
  assign kind    = kind_t'(s_axis_tuser);
  assign slot    = s_axis_tdata[11:0];
  assign value   = s_axis_tdata[43:12];
  assign start   = in_acc && (kind == KIND_START);

  assign n_c6   = (basis_size > 6'(MAX_BASIS)) ? 6'(MAX_BASIS) : basis_size;
  assign occ_c6 = (occupied_count > n_c6) ? n_c6 : occupied_count;
  assign empty  = (occ_c6 == 6'd0) || (occ_c6 == n_c6);

  assign n_last   = n_r - 1'b1;
  assign occ_last = occ_r - 1'b1;
  assign inner_last = (NW'(mm) == n_last) && (NW'(tt) == n_last) &&
                      (NW'(ll) == n_last) && (NW'(ss) == n_last);
  assign outer_last = (NW'(ii) == occ_last) && (NW'(jj) == occ_last) &&
                      (NW'(aa) == n_last) && (NW'(bb) == n_last);
  assign den_nz   = (den != '0);
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  // ---------------------------------------------------------------- stores
  mp2e_ram #(.DEPTH(CDEPTH), .AW(CAW), .DW(32)) u_coef (
    .clk   (clk),
    .we    (in_acc && kind == KIND_COEF && {1'b0, slot} < 13'(CDEPTH)),
    .waddr (CAW'(slot)),
    .wdata (value),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  mp2e_ram #(.DEPTH(MAX_BASIS), .AW(IW), .DW(32)) u_orb (
    .clk   (clk),
    .we    (in_acc && kind == KIND_ENERGY && {1'b0, slot} < 13'(MAX_BASIS)),
    .waddr (IW'(slot)),
    .wdata (value),
    .raddr (eng_raddr),
    .rdata (eng_rd)
  );

  mp2e_ram #(.DEPTH(IDEPTH), .AW(IAW), .DW(32)) u_int (
    .clk   (clk),
    .we    (in_acc && kind == KIND_INTEGRAL && {1'b0, slot} < 13'(IDEPTH)),
    .waddr (IAW'(slot)),
    .wdata (value),
    .raddr (int_raddr),
    .rdata (int_rd)
  );

  mp2e_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  mp2e_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .done (div_done),
    .quo  (quo)
  );

  // ------------------------------------------------------------ next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = empty ? ST_OUT : ST_READ;
      ST_READ:  if (rd == RD_LAST) state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = (k[1:0] == 2'b11) ? ST_ACC : ST_MUL;
      ST_ACC: begin
        if (k == K_X_LAST) state_next = inner_last ? ST_EREAD : ST_READ;
        else state_next = ST_MUL;
      end
      ST_EREAD: if (rd == RD_LAST) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_DIFF2;
      ST_DIFF2: state_next = ST_DIFFQ;
      ST_DIFFQ: begin
        if (den_nz) state_next = ST_QMUL;
        else state_next = outer_last ? ST_OUT : ST_READ;
      end
      ST_QMUL:  state_next = ST_QSET;
      ST_QSET:  state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_QFIN;
      ST_QFIN:  state_next = ST_EACC;
      ST_EACC:  state_next = outer_last ? ST_OUT : ST_READ;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    cfg_ready     = !rst;

    cp = ii;
    cq = ll;
    unique case (rd)
      3'd1:    begin cp = aa; cq = mm; end
      3'd2:    begin cp = jj; cq = ss; end
      3'd3:    begin cp = bb; cq = tt; end
      default: begin cp = ii; cq = ll; end
    endcase
    caddr_full = AW2'(cp) * AW2'(n_r) + AW2'(cq);
    coef_raddr = CAW'(caddr_full);

    g1_full = ((AW4'(ll) * AW4'(n_r) + AW4'(mm)) * AW4'(n_r) + AW4'(ss)) * AW4'(n_r)
              + AW4'(tt);
    g2_full = ((AW4'(ll) * AW4'(n_r) + AW4'(tt)) * AW4'(n_r) + AW4'(ss)) * AW4'(n_r)
              + AW4'(mm);
    int_raddr = (rd == 3'd0) ? IAW'(g1_full) : IAW'(g2_full);

    unique case (rd)
      3'd1:    eng_raddr = jj;
      3'd2:    eng_raddr = aa;
      3'd3:    eng_raddr = bb;
      default: eng_raddr = ii;
    endcase

    mul_en = (state == ST_MUL) || (state == ST_QMUL);
    mul_a  = p;
    mul_b  = g1;
    if (state == ST_QMUL) begin
      mul_a = dq;
      mul_b = diffq;
    end else begin
      unique case (k)
        3'd0: begin mul_a = zi; mul_b = za; end
        3'd1: begin mul_a = p;  mul_b = g1; end
        3'd2: begin mul_a = p;  mul_b = zj; end
        3'd3: begin mul_a = p;  mul_b = zb; end
        3'd4: begin mul_a = zi; mul_b = zb; end
        3'd5: begin mul_a = p;  mul_b = g2; end
        3'd6: begin mul_a = p;  mul_b = zj; end
        3'd7: begin mul_a = p;  mul_b = za; end
        default: begin mul_a = p; mul_b = g1; end
      endcase
    end

    un            = prod[63] ? 64'(-prod) : 64'(prod);
    div_ctl.start = (state == ST_QSET);
    div_ctl.num   = {un[62:0], 16'd0};
    div_ctl.dvs   = den[33] ? DEN_W'(-den) : DEN_W'(den);
  end

  // arithmetic helpers
  always_comb begin
    r24   = rnd24(prod);
    dd_s  = addsat(d, d);
    dq_s  = to_q24(d);
    ds_s  = subsat(diff, x);
    df_s  = to_q24(diff);
    acc_s = addsat((state == ST_EACC) ? energy : ((k == K_D_LAST) ? d : x),
                   (state == ST_EACC) ? qv : term);
    q_neg = dq[31] ^ diffq[31] ^ den[33];
    q_big = |quo[NUM_W-1:63];
  end

  // -------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      occupied_count <= 6'd1;
      basis_size     <= 6'd8;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_OCC:   occupied_count <= cfg_data;
          CFG_BASIS: basis_size     <= cfg_data;
          default:   basis_size     <= basis_size;
        endcase
      end
      if (state == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // -------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          n_r      <= NW'(n_c6);
          occ_r    <= NW'(occ_c6);
          ii       <= '0;
          jj       <= '0;
          aa       <= IW'(occ_c6);
          bb       <= IW'(occ_c6);
          mm       <= '0;
          tt       <= '0;
          ll       <= '0;
          ss       <= '0;
          rd       <= '0;
          k        <= '0;
          d        <= '0;
          x        <= '0;
          energy   <= '0;
          zero_den <= 1'b0;
          sat      <= 1'b0;
        end
      end
      ST_READ: begin
        rd <= (rd == RD_LAST) ? 3'd0 : rd + 1'b1;
        unique case (rd)
          3'd1:    begin zi <= coef_rd; g1 <= int_rd; end
          3'd2:    begin za <= coef_rd; g2 <= int_rd; end
          3'd3:    zj <= coef_rd;
          3'd4:    zb <= coef_rd;
          default: zb <= zb;
        endcase
      end
      ST_MUL: begin
        p <= p;
      end
      ST_RND: begin
        if (k[1:0] == 2'b11) begin
          term <= rnd8(prod);
        end else begin
          p   <= r24.v;
          sat <= sat | r24.sat;
          k   <= k + 1'b1;
        end
      end
      ST_ACC: begin
        sat <= sat | acc_s.sat;
        if (k == K_D_LAST) begin
          d <= acc_s.v;
          k <= k + 1'b1;
        end else begin
          x <= acc_s.v;
          k <= '0;
          // inner walk: m outer, then t, l, s innermost
          if (NW'(ss) == n_last) begin
            ss <= '0;
            if (NW'(ll) == n_last) begin
              ll <= '0;
              if (NW'(tt) == n_last) begin
                tt <= '0;
                mm <= (NW'(mm) == n_last) ? '0 : mm + 1'b1;
              end else tt <= tt + 1'b1;
            end else ll <= ll + 1'b1;
          end else ss <= ss + 1'b1;
        end
      end
      ST_EREAD: begin
        rd <= (rd == RD_LAST) ? 3'd0 : rd + 1'b1;
        unique case (rd)
          3'd1:    den <= $signed({{2{eng_rd[31]}}, eng_rd});
          3'd2:    den <= den + $signed({{2{eng_rd[31]}}, eng_rd});
          3'd3:    den <= den - $signed({{2{eng_rd[31]}}, eng_rd});
          3'd4:    den <= den - $signed({{2{eng_rd[31]}}, eng_rd});
          default: den <= den;
        endcase
      end
      ST_DIFF: begin
        diff <= dd_s.v;
        dq   <= dq_s.v;
        sat  <= sat | (den_nz & (dd_s.sat | dq_s.sat));
      end
      ST_DIFF2: begin
        diff <= ds_s.v;
        sat  <= sat | (den_nz & ds_s.sat);
      end
      ST_DIFFQ: begin
        diffq <= df_s.v;
        sat   <= sat | (den_nz & df_s.sat);
        if (!den_nz) begin
          zero_den <= 1'b1;
          d        <= '0;
          x        <= '0;
          // outer walk: i outer, then j, a, b innermost
          if (NW'(bb) == n_last) begin
            bb <= IW'(occ_r);
            if (NW'(aa) == n_last) begin
              aa <= IW'(occ_r);
              if (NW'(jj) == occ_last) begin
                jj <= '0;
                ii <= ii + 1'b1;
              end else jj <= jj + 1'b1;
            end else aa <= aa + 1'b1;
          end else bb <= bb + 1'b1;
        end
      end
      ST_QMUL, ST_QSET, ST_DIV: begin
        qv <= qv;
      end
      ST_QFIN: begin
        if (q_big) begin
          sat <= 1'b1;
          qv  <= q_neg ? Q64_MIN : Q64_MAX;
        end else begin
          qv <= q_neg ? -$signed({1'b0, quo[62:0]}) : $signed({1'b0, quo[62:0]});
        end
      end
      ST_EACC: begin
        energy <= acc_s.v;
        sat    <= sat | acc_s.sat;
        d      <= '0;
        x      <= '0;
        if (NW'(bb) == n_last) begin
          bb <= IW'(occ_r);
          if (NW'(aa) == n_last) begin
            aa <= IW'(occ_r);
            if (NW'(jj) == occ_last) begin
              jj <= '0;
              ii <= ii + 1'b1;
            end else jj <= jj + 1'b1;
          end else aa <= aa + 1'b1;
        end else bb <= bb + 1'b1;
      end
      ST_OUT: begin
        if (out_free) m_axis_tdata <= {6'd0, sat, zero_den, energy};
      end
      default: begin
        qv <= qv;
      end
    endcase
  end

  // ------------------------------------------------------------ assertions
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> state == ST_OUT)
    else $error("result overwritten while output stalled");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_OUT)
    else $error("output beat raised outside result state");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (NW'(mm) < n_r && NW'(ss) < n_r && NW'(bb) < n_r))
    else $error("loop index beyond basis size");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QSET) |=> (state == ST_DIV && !div_done))
    else $error("divider finished too early");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the MP2 correlation energy engine. Loads the orbital
// coefficient, orbital energy and integral stores, then starts the sum. Each
// start is checked against a cycle-free MP2 energy predictor, with random
// idle gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top import mp2e_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   NUM_ITEMS   = 1350;
  localparam int   MIN_STARTS  = 48;
  localparam int   CYCLE_LIMIT = 5000000;
  localparam int   DEPTH_COEF  = 64;
  localparam int   DEPTH_EORB  = 8;
  localparam int   DEPTH_ERI   = 4096;
  localparam int   BASIS_CAP   = 8;
  localparam longint E_MAX     = 64'sh7fff_ffff_ffff_ffff;
  localparam longint E_MIN     = 64'sh8000_0000_0000_0000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // slot[11:0], value[43:12]
  logic [1:0]             s_axis_tuser = '0;   // kind[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // energy[63:0], zero_den[64], sat[65]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_OCC;
  logic [5:0]             cfg_data = '0;

  mp2_energy_reduction dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic [63:0] energy;
    logic        zero_den;
    logic        sat;
  } energy_result_t;

  typedef struct {
    bit          is_cfg;
    logic [5:0]  occ;
    logic [5:0]  basis;
    kind_t       kind;
    logic [11:0] slot;
    logic [31:0] value;
    bit          zero_result;
  } vec_t;

  energy_result_t energy_q[$];
  vec_t           vectors[$];

  int  coef_mem [DEPTH_COEF];
  int  eorb_mem [DEPTH_EORB];
  int  eri_mem  [DEPTH_ERI];
  bit  coef_set [DEPTH_COEF];
  bit  eorb_set [DEPTH_EORB];
  bit  eri_set  [DEPTH_ERI];
  int  occ_reg   = 1;
  int  basis_reg = 8;
  bit  pred_sat;
  int  errors;
  int  items_sent;
  int  starts_sent;
  int  cycles;
  int  stall_left;
  bit  no_idle;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------- predictor ----------------
  function automatic longint sat_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) begin
      pred_sat = 1'b1;
      return s[64] ? E_MIN : E_MAX;
    end
    return s[63:0];
  endfunction

  function automatic longint clip_q24(input longint x);
    if (x > 64'sd2147483647) begin
      pred_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      pred_sat = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return clip_q24((a * b + (64'sd1 <<< 23)) >>> 24);
  endfunction

  function automatic longint five_prod(input longint f1, input longint f2, input longint g,
                                       input longint f3, input longint f4);
    longint p;
    p = round_mul(f1, f2);
    p = round_mul(p, g);
    p = round_mul(p, f3);
    return (p * f4 + 64'sd128) >>> 8;
  endfunction

  function automatic longint narrow_q24(input longint x);
    return clip_q24((x >>> 16) + longint'(x[15]));
  endfunction

  // a*b/den, truncated toward zero, result in q24.40
  function automatic longint scaled_quotient(input longint a, input longint b,
                                             input longint den);
    bit          neg;
    logic [63:0] ua, ub, ud, un, q, r, mag, lim;
    neg = ((a < 0) != (b < 0)) != (den < 0);
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    ud  = den < 0 ? -den : den;
    un  = ua * ub;
    q   = un / ud;
    r   = un % ud;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (q >= (64'd1 << 47)) mag = lim;
    else mag = (q << 16) + (r << 16) / ud;
    if (mag >= lim) begin
      if (mag > lim || q >= (64'd1 << 47)) pred_sat = 1'b1;
      mag = lim;
    end
    if (!neg) return mag;
    if (mag == 64'h8000_0000_0000_0000) return E_MIN;
    return -longint'(mag);
  endfunction

  function automatic energy_result_t mp2_energy();
    energy_result_t res;
    int     n, occ;
    longint acc, d, x, den, diff, zi, zj, za, zb, g1, g2;
    n   = basis_reg > BASIS_CAP ? BASIS_CAP : basis_reg;
    occ = occ_reg > n ? n : occ_reg;
    acc = 0;
    pred_sat = 1'b0;
    res.zero_den = 1'b0;
    for (int i = 0; i < occ; i++)
      for (int j = 0; j < occ; j++)
        for (int a = occ; a < n; a++)
          for (int b = occ; b < n; b++) begin
            d = 0;
            x = 0;
            for (int m = 0; m < n; m++)
              for (int t = 0; t < n; t++)
                for (int l = 0; l < n; l++)
                  for (int s = 0; s < n; s++) begin
                    zi = coef_mem[i*n + l];
                    zj = coef_mem[j*n + s];
                    za = coef_mem[a*n + m];
                    zb = coef_mem[b*n + t];
                    g1 = eri_mem[((l*n + m)*n + s)*n + t];
                    g2 = eri_mem[((l*n + t)*n + s)*n + m];
                    d = sat_add(d, five_prod(zi, za, g1, zj, zb));
                    x = sat_add(x, five_prod(zi, zb, g2, zj, za));
                  end
            den = longint'(eorb_mem[i]) + eorb_mem[j] - eorb_mem[a] - eorb_mem[b];
            if (den == 0) begin
              res.zero_den = 1'b1;
              continue;
            end
            diff = sat_add(sat_add(d, d), 0);
            if (x == E_MIN) diff = sat_add(sat_add(diff, E_MAX), 1);
            else diff = sat_add(diff, -x);
            acc = sat_add(acc, scaled_quotient(narrow_q24(d), narrow_q24(diff), den));
          end
    res.energy = acc;
    res.sat    = pred_sat;
    return res;
  endfunction

  // ---------------- input side ----------------
  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 1 << 25) - (1 << 24);
    if (r < 85) return '0;
    return $urandom;
  endfunction

  task automatic send_beat(input kind_t kind, input logic [11:0] slot,
                           input logic [31:0] value, input bit zero_result);
    int gap, r;
    energy_result_t res;
    r = $urandom_range(0, 99);
    gap = (no_idle || r < 60) ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(5, 30));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, value, slot};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    case (kind)
      KIND_COEF: begin
        if (slot < DEPTH_COEF) begin
          coef_mem[slot] = value;
          coef_set[slot] = 1'b1;
        end
      end
      KIND_ENERGY: begin
        if (slot < DEPTH_EORB) begin
          eorb_mem[slot] = value;
          eorb_set[slot] = 1'b1;
        end
      end
      KIND_INTEGRAL: begin
        eri_mem[slot] = value;
        eri_set[slot] = 1'b1;
      end
      default: begin
        starts_sent++;
        if (zero_result) begin
          res = '{energy: '0, zero_den: 1'b0, sat: 1'b0};
        end else begin
          res = mp2_energy();
        end
        energy_q.push_back(res);
      end
    endcase
  endtask

  // loads every entry the next non-empty sum reads that was never written, then sends the start
  task automatic start_sum(input bit zero_result);
    int n, occ;
    n   = basis_reg > BASIS_CAP ? BASIS_CAP : basis_reg;
    occ = occ_reg > n ? n : occ_reg;
    if (occ > 0 && occ < n) begin
      for (int k = 0; k < n*n; k++)
        if (!coef_set[k]) send_beat(KIND_COEF, 12'(k), rand_value(), 1'b0);
      for (int k = 0; k < n; k++)
        if (!eorb_set[k]) send_beat(KIND_ENERGY, 12'(k), rand_value(), 1'b0);
      for (int k = 0; k < n*n*n*n; k++)
        if (!eri_set[k]) send_beat(KIND_INTEGRAL, 12'(k), rand_value(), 1'b0);
    end
    send_beat(KIND_START, 12'($urandom_range(0, 4095)), $urandom, zero_result);
  endtask

  task automatic set_config(input int occ, input int basis);
    s_axis_tvalid <= 1'b0;
    wait (energy_q.size() == 0);
    repeat (20) @(posedge clk);
    for (int w = 0; w < 2; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (w == 0) ? CFG_OCC : CFG_BASIS;
      cfg_data  <= (w == 0) ? 6'(occ) : 6'(basis);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    occ_reg   = occ;
    basis_reg = basis;
  endtask

  function automatic void add_load(input kind_t kind, input int slot, input logic [31:0] value);
    vectors.push_back('{is_cfg: 1'b0, occ: '0, basis: '0, kind: kind, slot: 12'(slot),
                        value: value, zero_result: 1'b0});
  endfunction

  function automatic void add_cfg(input int occ, input int basis);
    vectors.push_back('{is_cfg: 1'b1, occ: 6'(occ), basis: 6'(basis), kind: KIND_COEF,
                        slot: '0, value: '0, zero_result: 1'b0});
  endfunction

  function automatic void add_start(input bit zero_result);
    vectors.push_back('{is_cfg: 1'b0, occ: '0, basis: '0, kind: KIND_START, slot: '0,
                        value: '0, zero_result: zero_result});
  endfunction

  // ---------------- output side ----------------
  always @(posedge clk) begin
    energy_result_t want;
    int r;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (energy_q.size() == 0) begin
          report("unexpected energy beat", m_axis_tdata[63:0], '0);
        end else begin
          want = energy_q.pop_front();
          if (m_axis_tdata[63:0] !== want.energy)
            report("energy", m_axis_tdata[63:0], want.energy);
          if (m_axis_tdata[64] !== want.zero_den)
            report("zero_denominator", 64'(m_axis_tdata[64]), 64'(want.zero_den));
          if (m_axis_tdata[65] !== want.sat)
            report("saturated", 64'(m_axis_tdata[65]), 64'(want.sat));
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!no_idle && r >= 80)
          stall_left <= (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int n, occ, r, count;
    kind_t kind;
    logic [11:0] slot;
    logic [31:0] same;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, ignored slots, zero denominator, empty sums
    add_cfg(1, 2);
    add_load(KIND_COEF, 0, 32'h7fff_ffff);
    add_load(KIND_COEF, 3, 32'h8000_0000);
    add_load(KIND_COEF, 64, 32'h1234_5678);
    add_load(KIND_COEF, 4095, 32'hffff_ffff);
    add_load(KIND_ENERGY, 0, 32'h0100_0000);
    add_load(KIND_ENERGY, 1, 32'h0100_0000);
    add_load(KIND_ENERGY, 8, 32'h5555_aaaa);
    add_load(KIND_ENERGY, 7, 32'h7fff_ffff);
    add_load(KIND_INTEGRAL, 0, 32'h7fff_ffff);
    add_load(KIND_INTEGRAL, 4095, 32'h8000_0000);
    add_load(KIND_INTEGRAL, 15, 32'hffff_ffff);
    add_start(1'b0);
    add_load(KIND_ENERGY, 1, 32'hff00_0000);
    add_load(KIND_COEF, 1, 32'h0080_0000);
    add_start(1'b0);
    add_cfg(2, 2);
    add_start(1'b1);
    add_cfg(0, 2);
    add_start(1'b1);
    add_cfg(0, 0);
    add_start(1'b1);
    add_cfg(32, 32);
    add_start(1'b1);

    foreach (vectors[k]) begin
      if (vectors[k].is_cfg) set_config(vectors[k].occ, vectors[k].basis);
      else if (vectors[k].kind == KIND_START) start_sum(vectors[k].zero_result);
      else send_beat(vectors[k].kind, vectors[k].slot, vectors[k].value, 1'b0);
    end

    while (items_sent < NUM_ITEMS || starts_sent < MIN_STARTS) begin
      r = $urandom_range(0, 99);
      n = (r < 70) ? 2 : (r < 95 ? 3 : 4);
      occ = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n + 2) : $urandom_range(1, n - 1);
      set_config(occ, n);
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(5, 30);
      repeat (count) begin
        kind = kind_t'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 80) begin
          case (kind)
            KIND_COEF:   slot = 12'($urandom_range(0, n*n - 1));
            KIND_ENERGY: slot = 12'($urandom_range(0, n - 1));
            default:     slot = 12'($urandom_range(0, n*n*n*n - 1));
          endcase
        end else begin
          slot = 12'($urandom_range(0, 4095));
        end
        send_beat(kind, slot, rand_value(), 1'b0);
      end
      // equal orbital energies make every denominator zero
      if ($urandom_range(0, 9) == 0) begin
        same = rand_value();
        for (int k = 0; k < n; k++) send_beat(KIND_ENERGY, 12'(k), same, 1'b0);
      end
      start_sum(1'b0);
      if ($urandom_range(0, 4) == 0) start_sum(1'b0);
      no_idle = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait (energy_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
